/* hdl/swh_pkg.sv */
// Shared constants, item type and command codes for the sliding window histogram.
package swh_pkg;

  localparam int unsigned WINDOW      = 1024;
  localparam int unsigned VALUE_RANGE = 65536;

  localparam int unsigned VAL_W  = 16;
  localparam int unsigned REP_W  = 11;
  localparam int unsigned FREQ_W = 11;

  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned CNT_AW = (VALUE_RANGE > 1) ? $clog2(VALUE_RANGE) : 1;
  localparam int unsigned WP_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QIDX_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef struct packed {
    logic             insert;
    logic             in_range;
    logic [VAL_W-1:0] value;
    logic [REP_W-1:0] reps;
  } item_t;

endpackage

/* hdl/sliding_window_histogram.sv */
// Top level of the sliding window histogram: front end, work queue and back end.
//
// Counts how often each 16-bit value occurs among the last WINDOW inserted values.
// Input channel (in_valid_i / in_stall_o): cmd_i selects add (insert value_i
// repeat_req_i times) or query; every beat yields exactly one result beat on the
// output channel (out_valid_o / out_stall_i) with the value's count after the item
// and the window-full flag. Adds with repeat_req_i above WINDOW change nothing.
// Flow: a beat waits in a two-entry queue; the back end then reads the count for
// the lookup. Each insertion is a count read and write before the ring first
// wraps and a ring read, evict read and write, and count read and write
// afterwards, all through the single port of the count store. The result is
// then loaded into the output register, and only after that does the back end
// pop its next item.
// Reset: the count store's VALUE_RANGE (65536) entries are cleared one entry per cycle,
// with in_stall_o high throughout; the ring pointer and full flag reset to zero.
// A stalled result holds in the output register while the queue accepts beats until
// full; the back end waits for the register before finishing its next item.
module sliding_window_histogram (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          cmd_i,
  input  logic [swh_pkg::VAL_W-1:0]     value_i,
  input  logic [swh_pkg::REP_W-1:0]     repeat_req_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [swh_pkg::FREQ_W-1:0]    frequency_o,
  output logic                          window_full_o
);

  logic           push;
  swh_pkg::item_t push_item;
  logic           q_full;
  logic           q_empty;
  logic           pop;
  swh_pkg::item_t pop_item;
  logic           clearing;

  swh_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .value_i      (value_i),
    .repeat_req_i (repeat_req_i),
    .q_full_i     (q_full),
    .clearing_i   (clearing),
    .push_o       (push),
    .item_o       (push_item)
  );

  swh_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_item),
    .full_o      (q_full),
    .pop_i       (pop),
    .pop_data_o  (pop_item),
    .empty_o     (q_empty)
  );

  swh_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_data_i      (pop_item),
    .pop_o         (pop),
    .clearing_o    (clearing),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .frequency_o   (frequency_o),
    .window_full_o (window_full_o)
  );

endmodule

/* hdl/swh_front.sv */
// Front end: accepts input beats, classifies them and pushes work into the queue.
module swh_front (
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           cmd_i,
  input  logic [swh_pkg::VAL_W-1:0]      value_i,
  input  logic [swh_pkg::REP_W-1:0]      repeat_req_i,
  input  logic                           q_full_i,
  input  logic                           clearing_i,
  output logic                           push_o,
  output swh_pkg::item_t                 item_o
);

  logic is_add;
  logic in_range;
  logic rep_ok;
  logic insert;

  assign is_add   = swh_pkg::cmd_e'(cmd_i) == swh_pkg::CMD_ADD;
  assign in_range = 32'(value_i) < swh_pkg::VALUE_RANGE;
  assign rep_ok   = 32'(repeat_req_i) <= swh_pkg::WINDOW;
  // Out-of-range, oversized or zero-repeat adds degrade to a plain lookup.
  assign insert   = is_add && in_range && rep_ok && (repeat_req_i != '0);

  assign in_stall_o = q_full_i || clearing_i;
  assign push_o     = in_valid_i && !in_stall_o;

  assign item_o.insert   = insert;
  assign item_o.in_range = in_range;
  assign item_o.value    = value_i;
  assign item_o.reps     = insert ? repeat_req_i : '0;

endmodule

/* hdl/swh_fifo.sv */
// Short work queue between the front end and the back end.
module swh_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  swh_pkg::item_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output swh_pkg::item_t pop_data_o,
  output logic           empty_o
);

  swh_pkg::item_t                mem_q [swh_pkg::QDEPTH];
  logic [swh_pkg::QIDX_W-1:0]    wptr_q;
  logic [swh_pkg::QIDX_W-1:0]    rptr_q;
  logic [swh_pkg::QCNT_W-1:0]    cnt_q;

  assign full_o     = cnt_q == swh_pkg::QCNT_W'(swh_pkg::QDEPTH);
  assign empty_o    = cnt_q == '0;
  assign pop_data_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

/* hdl/swh_back.sv */
// Back end: count store, history ring, insertion sequencer and result register.
module swh_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_empty_i,
  input  swh_pkg::item_t              q_data_i,
  output logic                        pop_o,
  output logic                        clearing_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [swh_pkg::FREQ_W-1:0]  frequency_o,
  output logic                        window_full_o
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_EVICT_RD,
    S_OLD_RD,
    S_OLD_WR,
    S_NEW_RD,
    S_NEW_WR,
    S_RES_RD,
    S_RES
  } state_e;

  localparam logic [swh_pkg::CNT_AW-1:0] CNT_LAST = swh_pkg::CNT_AW'(swh_pkg::VALUE_RANGE - 1);
  localparam logic [swh_pkg::WP_W-1:0]   WP_LAST  = swh_pkg::WP_W'(swh_pkg::WINDOW - 1);

  state_e                        state_q;
  logic [swh_pkg::CNT_AW-1:0]    clr_addr_q;
  swh_pkg::item_t                item_q;
  logic [swh_pkg::REP_W-1:0]     reps_q;
  logic [swh_pkg::WP_W-1:0]      wp_q;
  logic                          full_q;
  logic [swh_pkg::CNT_AW-1:0]    old_addr_q;
  logic                          out_valid_q;
  logic [swh_pkg::FREQ_W-1:0]    freq_q;
  logic                          wfull_q;

  logic [swh_pkg::VAL_W-1:0]     ring_mem [swh_pkg::WINDOW];
  logic [swh_pkg::VAL_W-1:0]     ring_rdata_q;
  logic                          ring_we;

  logic [swh_pkg::CNT_W-1:0]     cnt_mem [swh_pkg::VALUE_RANGE];
  logic [swh_pkg::CNT_W-1:0]     cnt_rdata_q;
  logic [swh_pkg::CNT_AW-1:0]    cnt_addr;
  logic                          cnt_we;
  logic [swh_pkg::CNT_W-1:0]     cnt_wdata;

  logic [swh_pkg::CNT_AW-1:0]    val_addr;
  logic                          wrap;
  logic                          out_free;

  assign val_addr = item_q.value[swh_pkg::CNT_AW-1:0];
  assign wrap     = wp_q == WP_LAST;
  assign out_free = !out_valid_q || !out_stall_i;

  assign pop_o         = (state_q == S_IDLE) && !q_empty_i;
  assign clearing_o    = state_q == S_CLEAR;
  assign out_valid_o   = out_valid_q;
  assign frequency_o   = freq_q;
  assign window_full_o = wfull_q;

  assign ring_we = state_q == S_NEW_RD;

  always_comb begin
    cnt_addr  = val_addr;
    cnt_we    = 1'b0;
    cnt_wdata = cnt_rdata_q + 1'b1;
    unique case (state_q)
      S_CLEAR: begin
        cnt_addr  = clr_addr_q;
        cnt_we    = 1'b1;
        cnt_wdata = '0;
      end
      S_OLD_RD: begin
        cnt_addr = ring_rdata_q[swh_pkg::CNT_AW-1:0];
      end
      S_OLD_WR: begin
        // Drop the evicted value's count, never below zero.
        cnt_addr  = old_addr_q;
        cnt_we    = cnt_rdata_q != '0;
        cnt_wdata = cnt_rdata_q - 1'b1;
      end
      S_NEW_WR: begin
        cnt_we = 1'b1;
      end
      S_IDLE, S_EVICT_RD, S_NEW_RD, S_RES_RD, S_RES: begin
        cnt_addr = val_addr;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[wp_q] <= item_q.value;
    end
    ring_rdata_q <= ring_mem[wp_q];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_addr] <= cnt_wdata;
    end
    cnt_rdata_q <= cnt_mem[cnt_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_addr_q  <= '0;
      wp_q        <= '0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
      reps_q      <= '0;
    end else begin
      // Drop the taken beat unless the result state reloads the register.
      if (out_valid_q && !out_stall_i && state_q != S_RES) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_addr_q <= clr_addr_q + 1'b1;
          if (clr_addr_q == CNT_LAST) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!q_empty_i) begin
            item_q <= q_data_i;
            reps_q <= q_data_i.reps;
            if (!q_data_i.insert) begin
              state_q <= S_RES_RD;
            end else if (full_q) begin
              state_q <= S_EVICT_RD;
            end else begin
              state_q <= S_NEW_RD;
            end
          end
        end
        S_EVICT_RD: begin
          state_q <= S_OLD_RD;
        end
        S_OLD_RD: begin
          old_addr_q <= ring_rdata_q[swh_pkg::CNT_AW-1:0];
          state_q    <= S_OLD_WR;
        end
        S_OLD_WR: begin
          state_q <= S_NEW_RD;
        end
        S_NEW_RD: begin
          state_q <= S_NEW_WR;
        end
        S_NEW_WR: begin
          // Advance the ring pointer; the first wrap marks the window full.
          wp_q   <= wrap ? '0 : wp_q + 1'b1;
          full_q <= full_q || wrap;
          reps_q <= reps_q - 1'b1;
          if (reps_q == swh_pkg::REP_W'(1)) begin
            state_q <= S_RES_RD;
          end else if (full_q || wrap) begin
            state_q <= S_EVICT_RD;
          end else begin
            state_q <= S_NEW_RD;
          end
        end
        S_RES_RD: begin
          state_q <= S_RES;
        end
        S_RES: begin
          if (out_free) begin
            freq_q      <= item_q.in_range ? swh_pkg::FREQ_W'(cnt_rdata_q) : '0;
            wfull_q     <= full_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
      endcase
    end
  end

  a_no_pop_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !pop_o)
    else $error("work popped during count store clear");

  a_reps_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_NEW_WR || state_q == S_EVICT_RD) |-> (reps_q != '0))
    else $error("insertion running with no repeats left");

  a_wrap_sets_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_NEW_WR && wrap) |=> (full_q && wp_q == '0))
    else $error("pointer wrap did not mark window full");

  a_evict_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OLD_WR) |-> (cnt_rdata_q != '0))
    else $error("evicted value has zero count");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(freq_q) && $stable(wfull_q)))
    else $error("pending result changed while stalled");

endmodule
